// ===== rtl/assert_macros.svh =====
// Assertion helpers for the detector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/mthd_pkg.sv =====
package mthd_pkg;

	localparam int FIELD_COUNT = 10;
	localparam int PW_W        = 32;
	localparam int FACTOR_W    = 16;
	localparam int CHAN_W      = 4;
	localparam int CNT_OUT_W   = 16;
	localparam int PROD_W      = PW_W + FACTOR_W;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd3000;
	localparam logic [CHAN_W-1:0]   RANK_RESET   = 4'd4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = FACTOR_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_FACTOR = 2'd0,
		REG_REFERENCE_RANK   = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                 hit;
		logic [CHAN_W-1:0]    channel;
		logic [CNT_OUT_W-1:0] count;
		logic                 pending;
	} result_t;

endpackage

// ===== rtl/median_threshold_hit_detector.sv =====
// Median-relative threshold hit detector. Each input transaction carries the
// powers of up to ten channels; the first CHANNELS are used. Unless lockout is
// set, the powers are ranked ascending and the one at rank reference_rank
// (clamped to CHANNELS-1) is multiplied exactly by threshold_factor. The
// lowest-numbered channel whose power strictly exceeds that product is
// reported as hit, its saturating counter is bumped and the sticky hit flag
// is set; clear_hit drops the flag before detection. Every input transaction
// yields exactly one output transaction. The block is a five-stage pipeline
// that accepts one transaction per cycle while the output side is ready. Stage
// one has one ranking lane per channel, stage two merges the lanes into the
// reference value, stage three holds the 32x16 product, stage four holds the
// per-channel compare results and stage five updates the counters and holds
// the result. A stage moves forward whenever the stage after it is empty or
// moving, so back-pressure only stops input once every stage is full.
// Configuration is a plain write port and should only be written while the
// pipeline is empty.
`include "assert_macros.svh"

module median_threshold_hit_detector
	import mthd_pkg::*;
#(
	parameter int CHANNELS    = 10,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PW_W-1:0]       power_ch0,
	input  logic [PW_W-1:0]       power_ch1,
	input  logic [PW_W-1:0]       power_ch2,
	input  logic [PW_W-1:0]       power_ch3,
	input  logic [PW_W-1:0]       power_ch4,
	input  logic [PW_W-1:0]       power_ch5,
	input  logic [PW_W-1:0]       power_ch6,
	input  logic [PW_W-1:0]       power_ch7,
	input  logic [PW_W-1:0]       power_ch8,
	input  logic [PW_W-1:0]       power_ch9,
	input  logic                  lockout_active,
	input  logic                  clear_hit,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic [CHAN_W-1:0]     hit_channel,
	output logic [CNT_OUT_W-1:0]  hit_channel_count,
	output logic                  hit_pending
);

	// Configuration registers.
	logic [FACTOR_W-1:0] factor_q;
	logic [CHAN_W-1:0]   rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
			rank_q   <= RANK_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				REG_REFERENCE_RANK:   rank_q   <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control. Each stage loads when the next one is empty or
	// loading itself.
	logic v1_s1, v2_s2, v3_s3, v4_s4, out_valid_q;
	logic en1, en2, en3, en4, en5;

	assign en5      = !out_valid_q || out_ready;
	assign en4      = !v4_s4 || en5;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) out_valid_q <= v4_s4;
		end
	end

	// Stage 1: one ranking lane per used channel.
	logic [FIELD_COUNT-1:0][PW_W-1:0] pw_in;
	logic [CHANNELS-1:0][CHAN_W-1:0]  pos;

	assign pw_in = {power_ch9, power_ch8, power_ch7, power_ch6, power_ch5,
		power_ch4, power_ch3, power_ch2, power_ch1, power_ch0};

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		mthd_rank_lane #(
			.CHANNELS(CHANNELS),
			.LANE    (g)
		) u_lane (
			.vals(pw_in[CHANNELS-1:0]),
			.pos (pos[g])
		);
	end

	logic [CHANNELS-1:0][PW_W-1:0]   pw_s1;
	logic [CHANNELS-1:0][CHAN_W-1:0] pos_s1;
	logic                            lock_s1, clear_s1;

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			pw_s1    <= pw_in[CHANNELS-1:0];
			pos_s1   <= pos;
			lock_s1  <= lockout_active;
			clear_s1 <= clear_hit;
		end
	end

	// Stage 2: merge the lanes; exactly one lane holds the requested position.
	logic [CHAN_W-1:0] rank_sat;
	logic [PW_W-1:0]   ref_sel;

	always_comb begin
		rank_sat = (rank_q >= CHAN_W'(CHANNELS)) ? CHAN_W'(CHANNELS - 1) : rank_q;
		ref_sel  = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (pos_s1[i] == rank_sat) begin
				ref_sel = ref_sel | pw_s1[i];
			end
		end
	end

	logic [CHANNELS-1:0][PW_W-1:0] pw_s2;
	logic [PW_W-1:0]               ref_s2;
	logic                          lock_s2, clear_s2;

	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			pw_s2    <= pw_s1;
			ref_s2   <= ref_sel;
			lock_s2  <= lock_s1;
			clear_s2 <= clear_s1;
		end
	end

	// Stage 3: exact threshold product.
	logic [CHANNELS-1:0][PW_W-1:0] pw_s3;
	logic [PROD_W-1:0]             thr_s3;
	logic                          lock_s3, clear_s3;

	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			pw_s3    <= pw_s2;
			thr_s3   <= PROD_W'(ref_s2) * PROD_W'(factor_q);
			lock_s3  <= lock_s2;
			clear_s3 <= clear_s2;
		end
	end

	// Stage 4: per-channel compare against the threshold.
	logic [CHANNELS-1:0] hit_vec;
	logic [CHANNELS-1:0] hit_vec_s4;
	logic                clear_s4;

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			hit_vec[i] = !lock_s3 && (PROD_W'(pw_s3[i]) > thr_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v3_s3) begin
			hit_vec_s4 <= hit_vec;
			clear_s4   <= clear_s3;
		end
	end

	// Stage 5: priority pick, counter and flag update, result register.
	result_t result;

	mthd_hit_update #(
		.CHANNELS   (CHANNELS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (en5 && v4_s4),
		.hit_vec(hit_vec_s4),
		.clear  (clear_s4),
		.result (result)
	);

	assign out_valid         = out_valid_q;
	assign hit               = result.hit;
	assign hit_channel       = result.channel;
	assign hit_channel_count = result.count;
	assign hit_pending       = result.pending;

	// A hit always leaves the sticky flag set.
	`ASSERT_IMPLY(a_hit_sets_flag, out_valid && hit, hit_pending)
	// A transaction without a hit reports channel and count as zero.
	`ASSERT_IMPLY(a_no_hit_zero, out_valid && !hit,
		(hit_channel == '0) && (hit_channel_count == '0))
	// Input stalls only under back-pressure at the output.
	`ASSERT_IMPLY(a_stall_cause, !in_ready, out_valid && !out_ready)
	// A reported channel is one of the used channels.
	`ASSERT_IMPLY(a_channel_range, out_valid && hit, hit_channel < CHAN_W'(CHANNELS))

endmodule

// ===== rtl/mthd_rank_lane.sv =====
// One lane of the ranking network: the stable ascending position of one value.
module mthd_rank_lane
	import mthd_pkg::*;
#(
	parameter int CHANNELS = 10,
	parameter int LANE     = 0
) (
	input  logic [CHANNELS-1:0][PW_W-1:0] vals,
	output logic [CHAN_W-1:0]             pos
);

	// Equal values are ordered by channel number, so every lane gets a
	// distinct position.
	always_comb begin
		pos = '0;
		for (int j = 0; j < CHANNELS; j++) begin
			if (j != LANE) begin
				if ((vals[j] < vals[LANE]) || ((vals[j] == vals[LANE]) && (j < LANE))) begin
					pos = pos + CHAN_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/mthd_hit_update.sv =====
// Picks the lowest hit channel, updates its saturating counter and the sticky
// flag, and holds the finished result.
module mthd_hit_update
	import mthd_pkg::*;
#(
	parameter int CHANNELS    = 10,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [CHANNELS-1:0] hit_vec,
	input  logic                clear,
	output result_t             result
);

	localparam int IDX_W = $clog2(CHANNELS);
	localparam int WIDE_W = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

	logic [COUNT_WIDTH-1:0] counts_q [CHANNELS];
	logic                   flag_q;
	result_t                result_q;

	logic                   any_hit;
	logic [IDX_W-1:0]       idx;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic [WIDE_W-1:0]      cnt_wide;
	logic                   flag_d;

	always_comb begin
		idx = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		any_hit  = |hit_vec;
		cnt_new  = (&counts_q[idx]) ? counts_q[idx] : counts_q[idx] + COUNT_WIDTH'(1);
		cnt_wide = WIDE_W'(cnt_new);
		flag_d   = (flag_q & ~clear) | any_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (load) begin
			flag_q <= flag_d;
			if (any_hit) begin
				counts_q[idx] <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q.hit     <= any_hit;
			result_q.channel <= any_hit ? CHAN_W'(idx) : '0;
			result_q.count   <= any_hit ? cnt_wide[CNT_OUT_W-1:0] : '0;
			result_q.pending <= flag_d;
		end
	end

	assign result = result_q;

endmodule

// ===== dv/tb_median_threshold_hit_detector.sv =====
module tb_median_threshold_hit_detector;
	timeunit 1ns;
	timeprecision 1ps;

	import mthd_pkg::*;

	// The block is built with its default channel count and counter width.
	localparam int NUM_CH       = 10;
	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASES       = 6;
	// The pipeline is five stages deep; this covers it with room to spare.
	localparam int SETTLE_CYCLES = 12;
	localparam int MAX_REPORTS   = 10;

	// Register indexes that decode to nothing; writes to them must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Normal pacing mixes short and long gaps; brisk pacing keeps both sides
	// busy with only the occasional short gap.
	typedef enum logic {
		PACE_NORMAL,
		PACE_BRISK
	} pace_t;

	// One power set as it crosses the input channel.
	typedef struct packed {
		logic [FIELD_COUNT-1:0][PW_W-1:0] pw;
		logic                             lockout;
		logic                             clear;
	} power_set_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FIELD_COUNT-1:0][PW_W-1:0] power_bus = '0;
	logic                  lockout_active = 1'b0;
	logic                  clear_hit = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  hit;
	logic [CHAN_W-1:0]     hit_channel;
	logic [CNT_OUT_W-1:0]  hit_channel_count;
	logic                  hit_pending;

	// Power sets waiting for the driver, and the results still owed by the block.
	power_set_t  sets_to_send[$];
	result_t     expected_results[$];
	int unsigned sets_queued = 0;
	int unsigned sets_taken = 0;
	int unsigned mismatch_count = 0;
	pace_t       pace = PACE_NORMAL;

	// Shadow copy of the detector state and its two registers.
	logic [CNT_OUT_W-1:0] hit_counts [NUM_CH] = '{default: '0};
	logic                 sticky_hit = 1'b0;
	logic [FACTOR_W-1:0]  shadow_factor = FACTOR_RESET;
	logic [CHAN_W-1:0]    shadow_rank = RANK_RESET;

	// Driver and receiver pacing state.
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned ready_hold = 0;
	int unsigned recv_calm = 0;

	median_threshold_hit_detector dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.power_ch0         (power_bus[0]),
		.power_ch1         (power_bus[1]),
		.power_ch2         (power_bus[2]),
		.power_ch3         (power_bus[3]),
		.power_ch4         (power_bus[4]),
		.power_ch5         (power_bus[5]),
		.power_ch6         (power_bus[6]),
		.power_ch7         (power_bus[7]),
		.power_ch8         (power_bus[8]),
		.power_ch9         (power_bus[9]),
		.lockout_active    (lockout_active),
		.clear_hit         (clear_hit),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.hit               (hit),
		.hit_channel       (hit_channel),
		.hit_channel_count (hit_channel_count),
		.hit_pending       (hit_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Computes the result of one power set and advances the shadow state.
	// The reference is found by counting: the value at rank r is the one with
	// at most r values strictly below it and more than r values at or below it.
	function automatic result_t detect_hit(input power_set_t s);
		logic [PW_W-1:0]   ref_pw;
		logic [PROD_W-1:0] limit;
		int unsigned       sel_rank;
		int unsigned       below;
		int unsigned       not_above;
		result_t           r;
		r = '0;
		ref_pw = '0;
		sel_rank = (shadow_rank >= NUM_CH) ? NUM_CH - 1 : shadow_rank;
		// The clear always acts before detection, so a hit on the same
		// transaction leaves the flag set.
		if (s.clear)
			sticky_hit = 1'b0;
		if (!s.lockout) begin
			for (int i = 0; i < NUM_CH; i++) begin
				below = 0;
				not_above = 0;
				for (int j = 0; j < NUM_CH; j++) begin
					if (s.pw[j] < s.pw[i])
						below++;
					if (s.pw[j] <= s.pw[i])
						not_above++;
				end
				if (below <= sel_rank && sel_rank < not_above)
					ref_pw = s.pw[i];
			end
			// Full 48-bit product, so nothing wraps before the compare.
			limit = PROD_W'(ref_pw) * PROD_W'(shadow_factor);
			for (int i = 0; i < NUM_CH; i++) begin
				if (!r.hit && PROD_W'(s.pw[i]) > limit) begin
					if (hit_counts[i] != '1)
						hit_counts[i] = hit_counts[i] + 1'b1;
					sticky_hit = 1'b1;
					r.hit = 1'b1;
					r.channel = CHAN_W'(i);
					r.count = hit_counts[i];
				end
			end
		end
		r.pending = sticky_hit;
		return r;
	endfunction

	function automatic power_set_t flat_set(input logic [PW_W-1:0] value);
		power_set_t s;
		s = '0;
		for (int i = 0; i < FIELD_COUNT; i++)
			s.pw[i] = value;
		return s;
	endfunction

	// Random power sets in several shapes. Uniform sets exercise every bit of
	// every field, extreme sets mix zero, one and all ones, and noise-floor
	// sets put spikes right around the threshold for the given factor so that
	// hits, near misses and exact ties all turn up.
	function automatic power_set_t random_set(input logic [FACTOR_W-1:0] factor);
		power_set_t        s;
		logic [PW_W-1:0]   floor_pw;
		logic [PROD_W-1:0] spike_pw;
		int unsigned       shape;
		int unsigned       spikes;
		s = '0;
		s.lockout = ($urandom_range(0, 5) == 0);
		s.clear = ($urandom_range(0, 3) == 0);
		shape = $urandom_range(0, 9);
		if (shape < 2) begin
			for (int i = 0; i < FIELD_COUNT; i++)
				s.pw[i] = $urandom();
		end else if (shape < 4) begin
			for (int i = 0; i < FIELD_COUNT; i++) begin
				case ($urandom_range(0, 3))
					0: s.pw[i] = '0;
					1: s.pw[i] = 1;
					2: s.pw[i] = '1;
					default: s.pw[i] = $urandom();
				endcase
			end
		end else begin
			floor_pw = $urandom_range(0, 1 << $urandom_range(0, 20));
			// A flat floor makes the reference exactly the floor value, which
			// is what lets the spikes land on the threshold itself.
			for (int i = 0; i < FIELD_COUNT; i++)
				s.pw[i] = (shape < 7) ? floor_pw : floor_pw + $urandom_range(0, floor_pw / 8);
			spikes = $urandom_range(0, 3);
			for (int k = 0; k < spikes; k++) begin
				spike_pw = PROD_W'(floor_pw) * PROD_W'(factor);
				case ($urandom_range(0, 3))
					0: if (spike_pw != 0) spike_pw = spike_pw - 1;
					1: ;
					2: spike_pw = spike_pw + 1;
					default: spike_pw = spike_pw + $urandom_range(0, 4096);
				endcase
				if (spike_pw > PROD_W'(32'hFFFF_FFFF))
					spike_pw = PROD_W'(32'hFFFF_FFFF);
				s.pw[$urandom_range(0, NUM_CH - 1)] = spike_pw[PW_W-1:0];
			end
		end
		return s;
	endfunction

	function automatic int unsigned gap_length(input pace_t p);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (p == PACE_BRISK)
			return (roll < 94) ? 0 : $urandom_range(1, 2);
		if (roll < 45)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_set(input power_set_t s);
		sets_to_send.push_back(s);
		sets_queued++;
	endtask

	// One register write: the enable is high for exactly one clock edge.
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Holds the stimulus back until every queued power set has been taken and
	// every result has come back, then lets the pipeline settle. Both counts
	// are updated together by the monitor, so the check cannot see half of an
	// update.
	task automatic wait_for_drain();
		@(posedge clk);
		while (sets_taken != sets_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver. A new transaction is presented only when the input channel is
	// empty or its current transaction is taken at this edge, so valid and the
	// payload never change while a transaction waits. After each transaction a
	// gap of random length may follow; now and then a calm stretch sends
	// back to back.
	always @(posedge clk) begin
		power_set_t next_set;
		if (arst_n && (!in_valid || in_ready)) begin
			if (send_gap != 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (sets_to_send.size() != 0) begin
				next_set = sets_to_send.pop_front();
				power_bus <= next_set.pw;
				lockout_active <= next_set.lockout;
				clear_hit <= next_set.clear;
				in_valid <= 1'b1;
				if (send_calm != 0) begin
					send_calm <= send_calm - 1;
				end else begin
					send_gap <= gap_length(pace);
					if ($urandom_range(0, 49) == 0)
						send_calm <= $urandom_range(20, 80);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor. It mirrors register writes into the shadow registers, predicts
	// a result for every accepted input transaction, checks every accepted
	// output transaction against the oldest prediction, and paces out_ready.
	always @(posedge clk) begin
		power_set_t  seen;
		result_t     got;
		result_t     want;
		int unsigned stall;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_THRESHOLD_FACTOR: shadow_factor = cfg_data;
					REG_REFERENCE_RANK: shadow_rank = cfg_data[CHAN_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && in_ready) begin
				seen.pw = power_bus;
				seen.lockout = lockout_active;
				seen.clear = clear_hit;
				expected_results.push_back(detect_hit(seen));
				sets_taken++;
			end

			if (out_valid && out_ready) begin
				got.hit = hit;
				got.channel = hit_channel;
				got.count = hit_channel_count;
				got.pending = hit_pending;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result transaction: ",
							"hit=%0d channel=%0d count=%0d pending=%0d",
							got.hit, got.channel, got.count, got.pending);
				end else begin
					want = expected_results.pop_front();
					if (got.hit !== want.hit || got.channel !== want.channel ||
							got.count !== want.count || got.pending !== want.pending) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("result mismatch: expected ",
								"hit=%0d channel=%0d count=%0d pending=%0d",
								want.hit, want.channel, want.count, want.pending,
								", got hit=%0d channel=%0d count=%0d pending=%0d",
								got.hit, got.channel, got.count, got.pending);
					end
				end
			end

			// Receiver pacing: ready stays high for a random run, then drops
			// for a gap drawn like the sender's; calm stretches keep it high.
			if (ready_hold != 0) begin
				ready_hold <= ready_hold - 1;
			end else if (!out_ready) begin
				out_ready <= 1'b1;
				ready_hold <= $urandom_range(0, 12);
			end else if (recv_calm != 0) begin
				recv_calm <= recv_calm - 1;
			end else begin
				stall = gap_length(pace);
				if ($urandom_range(0, 39) == 0) begin
					recv_calm <= $urandom_range(30, 100);
				end else if (stall != 0) begin
					out_ready <= 1'b0;
					ready_hold <= stall - 1;
				end
			end
		end
	end

	// Stimulus and end of test.
	initial begin
		power_set_t          s;
		logic [FACTOR_W-1:0] factor_now;
		logic [CHAN_W-1:0]   rank_now;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets under the reset values: factor 3000, rank 4.
		// All zero and all ones give no hit; the all-ones product must not
		// wrap.
		queue_set(flat_set('0));
		queue_set(flat_set('1));
		// A spike one above the threshold hits on the last channel.
		s = flat_set(1);
		s.pw[9] = 3001;
		queue_set(s);
		// A spike exactly at the threshold is not a hit; the flag stays up.
		s = flat_set(1);
		s.pw[3] = 3000;
		queue_set(s);
		// A clear with no hit drops the flag.
		s = flat_set(1);
		s.clear = 1'b1;
		queue_set(s);
		// A clear together with a hit leaves the flag set.
		s = flat_set(1);
		s.clear = 1'b1;
		s.pw[0] = 3001;
		queue_set(s);
		// Lockout hides even the largest spike, and lockout with a clear
		// still drops the flag.
		s = flat_set(1);
		s.lockout = 1'b1;
		s.pw[0] = '1;
		queue_set(s);
		s.clear = 1'b1;
		queue_set(s);
		// Two spikes: the lower channel wins.
		s = flat_set(1);
		s.pw[2] = 9000;
		s.pw[7] = 9000;
		queue_set(s);
		// A zero reference makes the first nonzero channel a hit.
		s = flat_set('0);
		for (int i = 5; i < NUM_CH; i++)
			s.pw[i] = i - 4;
		queue_set(s);
		for (int i = 0; i < NUM_CH; i++)
			s.pw[i] = (i % 2 == 0) ? '0 : '1;
		queue_set(s);

		// Zero factor with a rank past the last channel: the threshold is
		// zero whatever the reference.
		wait_for_drain();
		program_reg(REG_THRESHOLD_FACTOR, 16'd0);
		program_reg(REG_REFERENCE_RANK, 16'd15);
		queue_set(flat_set('0));
		s = flat_set('0);
		s.pw[6] = 1;
		queue_set(s);

		// Rank past the last channel selects the largest power: no hit.
		wait_for_drain();
		program_reg(REG_THRESHOLD_FACTOR, 16'd1);
		program_reg(REG_REFERENCE_RANK, 16'd12);
		for (int i = 0; i < NUM_CH; i++)
			s.pw[i] = i + 1;
		s.lockout = 1'b0;
		s.clear = 1'b0;
		queue_set(s);

		// Rank 8 written with junk in the upper data bits, which the
		// register must ignore. Then writes to the undecoded indexes must
		// change nothing.
		wait_for_drain();
		program_reg(REG_REFERENCE_RANK, 16'hFFF8);
		queue_set(s);
		wait_for_drain();
		program_reg(REG_SPARE_2, 16'h0000);
		program_reg(REG_SPARE_3, 16'hFFFF);
		queue_set(s);

		// Largest factor against the smallest rank.
		wait_for_drain();
		program_reg(REG_THRESHOLD_FACTOR, 16'hFFFF);
		program_reg(REG_REFERENCE_RANK, 16'd0);
		s = flat_set(1);
		s.pw[4] = 65536;
		queue_set(s);
		queue_set(flat_set('1));
		s = flat_set('0);
		s.pw[8] = 1;
		queue_set(s);

		// Random phases, each with its own register settings, extremes first.
		// One phase runs with brisk pacing so that long back-to-back bursts
		// fill the pipeline.
		for (int p = 0; p < PHASES; p++) begin
			wait_for_drain();
			pace = (p == 1) ? PACE_BRISK : PACE_NORMAL;
			case (p)
				0: begin factor_now = FACTOR_RESET; rank_now = RANK_RESET; end
				1: begin factor_now = 16'd1; rank_now = 4'd0; end
				2: begin factor_now = 16'hFFFF; rank_now = 4'd9; end
				3: begin factor_now = 16'd0; rank_now = 4'd15; end
				4: begin
					factor_now = FACTOR_W'($urandom_range(1, 8));
					rank_now = CHAN_W'($urandom_range(0, 15));
				end
				default: begin
					factor_now = FACTOR_W'($urandom_range(0, 65535));
					rank_now = CHAN_W'($urandom_range(0, 15));
				end
			endcase
			program_reg(REG_THRESHOLD_FACTOR, factor_now);
			program_reg(REG_REFERENCE_RANK,
				(CFG_DATA_W'($urandom) & 16'hFFF0) | CFG_DATA_W'(rank_now));
			if (p == PHASES - 1)
				program_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
			for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
				// Halfway through one phase the sender holds off until the
				// pipeline has emptied completely.
				if (p == 2 && k == RANDOM_ITEMS / (2 * PHASES))
					wait_for_drain();
				queue_set(random_set(factor_now));
			end
		end

		wait_for_drain();
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: several times the slowest correct run.
	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mthd_pkg.sv
rtl/mthd_rank_lane.sv
rtl/mthd_hit_update.sv
rtl/median_threshold_hit_detector.sv
dv/tb_median_threshold_hit_detector.sv
